// ===== hw/rtl/mf_pkg.sv =====
// ----------------------------------------------------------------------------
// mf_pkg
// Shared types and constants of the 5x5 median filter.
// ----------------------------------------------------------------------------
package mf_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int WINDOW_DEF    = 5;
   localparam int MAX_HEIGHT    = 4096;
   localparam int PASS_LIMIT    = 3;

   localparam logic [12:0] WIDTH_RST  = 13'd640;
   localparam logic [12:0] HEIGHT_RST = 13'd480;
   localparam logic [4:0]  LIMIT_RST  = 5'd5;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_LIMIT  = 2'd2,
      CSR_NONE   = 2'd3
   } csr_index_type;

   // what the back end does with a queued item
   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_PASS   = 2'd1,
      KIND_BORDER = 2'd2,
      KIND_MEDIAN = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  pixel;
      logic [11:0] cx;
      logic [11:0] cy;
   } meta_type;

endpackage

// ===== hw/rtl/median_filter_5x5.sv =====
// ----------------------------------------------------------------------------
// median_filter_5x5
// Streaming 5x5 median filter over 8-bit grey pixels in raster order.
// ----------------------------------------------------------------------------
// One pixel transfer per clock is sustained while the output is not stalled.
// A pixel goes through a position and classification stage that reads the
// line stores and shifts the window, a two-entry queue, and a rank pipeline
// (compare, count, select) into the output register. Results appear for
// every pixel in pass-through mode, else only once the window has WINDOW
// rows and columns; border centres give value 0, interior centres the
// median. Configuration writes are accepted at any time but must only be
// issued while the block is idle.
module median_filter_5x5
   import mf_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int WINDOW    = WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_value,
   output logic [11:0] rsp_center_x,
   output logic [11:0] rsp_center_y,
   output logic        rsp_interior,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   localparam int WBITS = WINDOW * WINDOW * 8;
   localparam int QW    = $bits(meta_type) + WBITS;

   logic             q_push, q_full, q_pop, q_valid;
   meta_type         push_meta, head_meta;
   logic [WBITS-1:0] push_win, head_win;
   logic [QW-1:0]    head_data;

   mf_front #(.MAX_WIDTH(MAX_WIDTH), .WINDOW(WINDOW)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .q_push          (q_push),
      .q_meta          (push_meta),
      .q_window        (push_win),
      .q_full          (q_full)
   );

   mf_queue #(.WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({push_meta, push_win}),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (head_data)
   );

   assign head_meta = head_data[QW-1 -: $bits(meta_type)];
   assign head_win  = head_data[WBITS-1:0];

   mf_back #(.WINDOW(WINDOW)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_meta       (head_meta),
      .q_window     (head_win),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_value    (rsp_value),
      .rsp_center_x (rsp_center_x),
      .rsp_center_y (rsp_center_y),
      .rsp_interior (rsp_interior)
   );

endmodule

// ===== hw/rtl/mf_ram.sv =====
// ----------------------------------------------------------------------------
// mf_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module mf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mf_front.sv =====
// ----------------------------------------------------------------------------
// mf_front
// Takes pixels, tracks raster position, keeps line stores and the window,
// and classifies each pixel into a queue item for the back end.
// ----------------------------------------------------------------------------
module mf_front
   import mf_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int WINDOW    = WINDOW_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_pixel,
   input  logic                          req_frame_start,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [12:0]                   csr_data,
   output logic                          q_push,
   output meta_type                      q_meta,
   output logic [WINDOW*WINDOW*8-1:0]    q_window,
   input  logic                          q_full
);

   localparam int TAPS  = WINDOW * WINDOW;
   localparam int LINES = WINDOW - 1;
   localparam int HALF  = (WINDOW - 1) / 2;
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int BW    = $clog2(LINES);

   logic [12:0] width_ff, height_ff;
   logic [4:0]  limit_ff;

   logic [CW-1:0] col_ff;
   logic [12:0]   row_ff;
   logic [BW-1:0] bank_ff;

   logic          b_valid_ff;
   logic [7:0]    b_pix_ff;
   logic [BW-1:0] b_bank_ff;
   kind_type      b_kind_ff;
   logic [11:0]   b_cx_ff, b_cy_ff;

   logic [7:0] win_ff [TAPS];
   logic [7:0] win_in [TAPS];
   logic [7:0] rd_data [LINES];
   logic [7:0] col_pix [WINDOW];

   logic          accept, b_adv;
   logic [CW-1:0] w_c, x, c0;
   logic [12:0]   h_c, y, r0, r1;
   logic [BW-1:0] b0, b1, bank_y;
   logic [4:0]    margin;
   logic [CW:0]   cx_full;
   logic [13:0]   cy_full;
   logic          full, in_margin;
   kind_type      kind_a;
   logic [11:0]   cx_a, cy_a;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         limit_ff  <= LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_LIMIT:  limit_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign b_adv     = b_valid_ff && ((b_kind_ff == KIND_NONE) || !q_full);
   assign req_ready = !b_valid_ff || b_adv;
   assign accept    = req_valid && req_ready;

   // raster position and classification of the incoming pixel
   always_comb begin
      if (width_ff == 13'd0) begin
         w_c = CW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_c = CW'(MAX_WIDTH);
      end else begin
         w_c = CW'(width_ff);
      end
      if (height_ff == 13'd0) begin
         h_c = 13'd1;
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_c = 13'(MAX_HEIGHT);
      end else begin
         h_c = height_ff;
      end
      c0 = req_frame_start ? '0 : col_ff;
      r0 = req_frame_start ? '0 : row_ff;
      b0 = req_frame_start ? '0 : bank_ff;
      if (c0 >= w_c) begin
         x  = '0;
         r1 = r0 + 13'd1;
         b1 = (int'(b0) == LINES - 1) ? '0 : b0 + BW'(1);
      end else begin
         x  = c0;
         r1 = r0;
         b1 = b0;
      end
      if (r1 >= h_c) begin
         y      = '0;
         bank_y = '0;
      end else begin
         y      = r1;
         bank_y = b1;
      end

      margin    = 5'(({1'b0, limit_ff} + 6'd1) >> 1);
      full      = (int'(x) >= WINDOW - 1) && (int'(y) >= WINDOW - 1);
      cx_full   = (CW+1)'(x) - (CW+1)'(HALF);
      cy_full   = 14'(y) - 14'(HALF);
      in_margin = (cx_full >= (CW+1)'(margin))
               && (cx_full + (CW+1)'(margin) < (CW+1)'(w_c))
               && (cy_full >= 14'(margin)) && (cy_full + 14'(margin) < 14'(h_c));

      priority if (int'(limit_ff) < PASS_LIMIT) begin
         kind_a = KIND_PASS;
         cx_a   = 12'(x);
         cy_a   = 12'(y);
      end else if (full && in_margin) begin
         kind_a = KIND_MEDIAN;
         cx_a   = 12'(cx_full);
         cy_a   = 12'(cy_full);
      end else if (full) begin
         kind_a = KIND_BORDER;
         cx_a   = 12'(cx_full);
         cy_a   = 12'(cy_full);
      end else begin
         kind_a = KIND_NONE;
         cx_a   = 12'(x);
         cy_a   = 12'(y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         bank_ff    <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff  <= x + CW'(1);
            row_ff  <= y;
            bank_ff <= bank_y;
         end
         if (accept) begin
            b_valid_ff <= 1'b1;
         end else if (b_adv) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_pix_ff  <= req_pixel;
         b_bank_ff <= bank_y;
         b_kind_ff <= kind_a;
         b_cx_ff   <= cx_a;
         b_cy_ff   <= cy_a;
      end
   end

   for (genvar i = 0; i < LINES; i++) begin : g_line
      mf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram (
         .clock   (clock),
         .wr_en   (accept && (int'(bank_y) == i)),
         .wr_addr (x[AW-1:0]),
         .wr_data (req_pixel),
         .rd_en   (accept),
         .rd_addr (x[AW-1:0]),
         .rd_data (rd_data[i])
      );
   end

   // new window column, oldest row first, shifted into the window
   always_comb begin
      logic [BW:0] sel;
      for (int r = 0; r < LINES; r++) begin
         sel = (BW+1)'(b_bank_ff) + (BW+1)'(r);
         if (int'(sel) >= LINES) begin
            sel = sel - (BW+1)'(LINES);
         end
         col_pix[r] = rd_data[sel[BW-1:0]];
      end
      col_pix[WINDOW-1] = b_pix_ff;
      for (int r = 0; r < WINDOW; r++) begin
         for (int c = 0; c < WINDOW - 1; c++) begin
            win_in[r*WINDOW+c] = win_ff[r*WINDOW+c+1];
         end
         win_in[r*WINDOW+WINDOW-1] = col_pix[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else if (b_adv) begin
         for (int i = 0; i < TAPS; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         q_window[i*8 +: 8] = win_in[i];
      end
   end

   assign q_push       = b_adv && (b_kind_ff != KIND_NONE);
   assign q_meta.kind  = b_kind_ff;
   assign q_meta.pixel = b_pix_ff;
   assign q_meta.cx    = b_cx_ff;
   assign q_meta.cy    = b_cy_ff;

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("push into full queue");
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_adv) |-> !req_ready) else $error("accept while stage stalled");
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> b_valid_ff) else $error("accepted pixel lost");

endmodule

// ===== hw/rtl/mf_queue.sv =====
// ----------------------------------------------------------------------------
// mf_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module mf_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_data  = entry_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/mf_back.sv =====
// ----------------------------------------------------------------------------
// mf_back
// Rank-based median over the window: compare, count ranks, select; then the
// result register.
// ----------------------------------------------------------------------------
module mf_back
   import mf_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  meta_type                   q_meta,
   input  logic [WINDOW*WINDOW*8-1:0] q_window,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_value,
   output logic [11:0]                rsp_center_x,
   output logic [11:0]                rsp_center_y,
   output logic                       rsp_interior
);

   localparam int TAPS = WINDOW * WINDOW;
   localparam int MID  = (TAPS - 1) / 2;
   localparam int RW   = $clog2(TAPS);

   logic                     en;
   logic                     p1_valid_ff, p2_valid_ff, rsp_valid_ff;
   meta_type                 p1_meta_ff, p2_meta_ff;
   logic [TAPS*8-1:0]        p1_win_ff, p2_win_ff;
   logic [TAPS-1:0]          prec_in [TAPS];
   logic [TAPS-1:0]          prec_ff [TAPS];
   logic [RW-1:0]            rank_in [TAPS];
   logic [RW-1:0]            rank_ff [TAPS];
   logic [7:0]               med;
   logic [7:0]               value_in;
   logic [7:0]               rsp_value_ff;
   logic [11:0]              rsp_cx_ff, rsp_cy_ff;
   logic                     rsp_int_ff;

   assign en    = !rsp_valid_ff || rsp_ready;
   assign q_pop = en && q_valid;

   // element j precedes element i in a stable sort
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         for (int j = 0; j < TAPS; j++) begin
            if (j < i) begin
               prec_in[i][j] = q_window[j*8 +: 8] <= q_window[i*8 +: 8];
            end else if (j > i) begin
               prec_in[i][j] = q_window[j*8 +: 8] < q_window[i*8 +: 8];
            end else begin
               prec_in[i][j] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         rank_in[i] = RW'($countones(prec_ff[i]));
      end
   end

   always_comb begin
      med = '0;
      for (int i = 0; i < TAPS; i++) begin
         if (int'(rank_ff[i]) == MID) begin
            med = med | p2_win_ff[i*8 +: 8];
         end
      end
      unique case (p2_meta_ff.kind)
         KIND_PASS:   value_in = p2_meta_ff.pixel;
         KIND_MEDIAN: value_in = med;
         default:     value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff  <= q_valid;
         p2_valid_ff  <= p1_valid_ff;
         rsp_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_meta_ff   <= q_meta;
         p1_win_ff    <= q_window;
         p2_meta_ff   <= p1_meta_ff;
         p2_win_ff    <= p1_win_ff;
         for (int i = 0; i < TAPS; i++) begin
            prec_ff[i] <= prec_in[i];
            rank_ff[i] <= rank_in[i];
         end
         rsp_value_ff <= value_in;
         rsp_cx_ff    <= p2_meta_ff.cx;
         rsp_cy_ff    <= p2_meta_ff.cy;
         rsp_int_ff   <= p2_meta_ff.kind == KIND_MEDIAN;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_center_x = rsp_cx_ff;
   assign rsp_center_y = rsp_cy_ff;
   assign rsp_interior = rsp_int_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(p1_valid_ff) && $stable(p2_valid_ff))
      else $error("pipeline moved while output stalled");
   a_pop_enters: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> p1_valid_ff) else $error("popped item lost");
   a_p2_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (p2_valid_ff && en) |=> rsp_valid_ff) else $error("result lost");

endmodule
